// ===== rtl/core/slid_pkg.sv =====
// shared types and constants of the sorted list engine
// no dependencies
`default_nettype none

package slid_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic  capture;    // latch compare flags against value
        logic  do_insert;  // apply an insert this cycle
        logic  do_delete;  // apply a delete this cycle
        t_data value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/slid_cell.sv =====
// one slot of the sorted row: entry, valid bit and latched compare flags
// depends on slid_pkg
`default_nettype none

module slid_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire slid_pkg::t_cell_cmd  i_cmd,
    input  wire                       i_left_ge,
    input  wire slid_pkg::t_data      i_left_entry,
    input  wire                       i_left_valid,
    input  wire slid_pkg::t_data      i_right_entry,
    input  wire                       i_right_valid,
    output logic                      o_ge,
    output logic                      o_eq,
    output slid_pkg::t_data           o_entry,
    output logic                      o_valid
);

    slid_pkg::t_data r_entry;
    logic            r_valid;
    logic            r_ge;
    logic            r_eq;

    // compare flags, taken when the item is accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ge <= !r_valid || (r_entry >= i_cmd.value);
            r_eq <= r_valid && (r_entry == i_cmd.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.do_insert) begin
            if (i_left_ge) begin
                r_valid <= i_left_valid;
            end else if (r_ge) begin
                r_valid <= 1'b1;
            end
        end else if (i_cmd.do_delete && r_ge) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            if (i_left_ge) begin
                r_entry <= i_left_entry;
            end else if (r_ge) begin
                r_entry <= i_cmd.value;
            end
        end else if (i_cmd.do_delete && r_ge) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_ge    = r_ge;
    assign o_eq    = r_eq;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_insert_delete.sv =====
// top level of the sorted list engine: control, count and row of cells
// depends on slid_pkg and slid_cell
`default_nettype none

// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_kind, i_value
// result    out        o_valid / i_ready    o_status, o_entry_count
//
// each item has an accept step that latches the compares in every cell,
// then an apply step that resolves found/full and shifts the row by one slot
// the result goes to an output register, so a new item is accepted while
// the previous result waits; the apply cycle holds while that register is full
// reset clears the count, the result valid bit, the cell valid bits and the control state
// entry values need no reset since invalid cells are never used

module sorted_list_insert_delete #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire                                  i_kind,
    input  wire signed [slid_pkg::DATA_W-1:0]    i_value,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [slid_pkg::STATUS_W-1:0]        o_status,
    output logic [slid_pkg::COUNT_W-1:0]         o_entry_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    slid_pkg::t_state     r_state, n_state;
    logic                 r_kind;
    slid_pkg::t_data      r_value;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid;
    logic [slid_pkg::STATUS_W-1:0] r_status;
    logic [slid_pkg::COUNT_W-1:0]  r_out_count;

    slid_pkg::t_cell_cmd  cmd;
    logic                 accept;
    logic                 apply;
    logic                 found;
    logic                 full;
    logic [CW-1:0]        next_count;
    logic [slid_pkg::STATUS_W-1:0] next_status;
    logic [CW+slid_pkg::COUNT_W-1:0] count_ext;

    logic                 ge_vec   [CAPACITY];
    logic [CAPACITY-1:0]  eq_vec;
    slid_pkg::t_data      entry_vec[CAPACITY];
    logic                 valid_vec[CAPACITY];

    // result register free, or being emptied this cycle
    logic                 out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == slid_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign apply    = (r_state == slid_pkg::S_EXEC) && out_free;

    // sorted row: equal entries are adjacent, and the first flag set
    // sits at the first entry not below the value
    assign found = |eq_vec;
    assign full  = (r_count >= CW'(CAPACITY));

    always_comb begin
        next_count  = r_count;
        next_status = slid_pkg::ST_NOT_FOUND;
        if (r_kind == slid_pkg::KIND_INSERT) begin
            if (full) begin
                next_status = slid_pkg::ST_FULL;
            end else begin
                next_status = slid_pkg::ST_INSERTED;
                next_count  = r_count + CW'(1);
            end
        end else if (found) begin
            next_status = slid_pkg::ST_DELETED;
            next_count  = r_count - CW'(1);
        end
    end

    // low bits of the count, zero padded for small capacities
    assign count_ext = {{slid_pkg::COUNT_W{1'b0}}, next_count};

    always_comb begin
        cmd.capture   = accept;
        cmd.do_insert = apply && (r_kind == slid_pkg::KIND_INSERT) && !full;
        cmd.do_delete = apply && (r_kind == slid_pkg::KIND_DELETE) && found;
        cmd.value     = accept ? i_value : r_value;
    end

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slid_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = slid_pkg::S_EXEC;
                end
            end
            slid_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = slid_pkg::S_IDLE;
                end
            end
            default: n_state = slid_pkg::S_IDLE;
        endcase
    end

    // held item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (apply) begin
            r_count <= next_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_status    <= next_status;
            r_out_count <= count_ext[slid_pkg::COUNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;

    // row of cells, slot 0 holds the smallest entry
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            left_ge;
        slid_pkg::t_data left_entry;
        logic            left_valid;
        slid_pkg::t_data right_entry;
        logic            right_valid;

        if (g == 0) begin : g_head
            assign left_ge    = 1'b0;
            assign left_entry = '0;
            assign left_valid = 1'b0;
        end else begin : g_mid
            assign left_ge    = ge_vec[g-1];
            assign left_entry = entry_vec[g-1];
            assign left_valid = valid_vec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_entry = entry_vec[g+1];
            assign right_valid = valid_vec[g+1];
        end

        slid_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_ge     (left_ge),
            .i_left_entry  (left_entry),
            .i_left_valid  (left_valid),
            .i_right_entry (right_entry),
            .i_right_valid (right_valid),
            .o_ge          (ge_vec[g]),
            .o_eq          (eq_vec[g]),
            .o_entry       (entry_vec[g]),
            .o_valid       (valid_vec[g])
        );
    end

endmodule

`default_nettype wire
